// ===== src/ogpm_pkg.sv =====
// ----------------------------------------------------------------------------
// ogpm_pkg
// Shared types, widths, reset values and codes of the occupancy grid point
// marker.
// ----------------------------------------------------------------------------
package ogpm_pkg;

   localparam int GRID_SIDE_DEF = 256;

   localparam int COORD_W     = 24;
   localparam int ROT_W       = 16;
   localparam int TRANS_W     = 21;
   localparam int HW_W        = 16;
   localparam int Q14_SHIFT   = 14;
   localparam int PROD_W      = COORD_W + ROT_W;
   localparam int SQ_W        = 2 * COORD_W;
   localparam int ACC_W       = PROD_W + 2;
   localparam int SCALE_W     = 16;
   localparam int SCALED_W    = ACC_W + SCALE_W + 1;
   localparam int SCALE_SHIFT = 30;
   localparam int CELL_W      = SCALED_W - SCALE_SHIFT;
   localparam int OUT_W       = 16;
   localparam int WORD_W      = 64;
   localparam int BIT_SEL_W   = 6;
   localparam int RANGE_W     = 36;

   localparam int CSR_DATA_W  = 63;
   localparam int CSR_INDEX_W = 3;

   localparam logic [SQ_W-1:0] MIN_RANGE_SQ = SQ_W'(16384);

   localparam logic signed [CELL_W-1:0] SAT_HI = CELL_W'(32767);
   localparam logic signed [CELL_W-1:0] SAT_LO = -CELL_W'(32768);

   localparam logic STATUS_NEW     = 1'b0;
   localparam logic STATUS_OUTSIDE = 1'b1;

   localparam logic [47:0]          ROT_ROW_X_RST  = 48'h0000_0000_4000;
   localparam logic [47:0]          ROT_ROW_Y_RST  = 48'h0000_4000_0000;
   localparam logic [47:0]          ROT_ROW_Z_RST  = 48'h4000_0000_0000;
   localparam logic [62:0]          TRANS_RST      = 63'd0;
   localparam logic [31:0]          HEIGHT_WIN_RST = 32'h0200_004D;
   localparam logic [RANGE_W-1:0]   MAX_RANGE_RST  = 36'd104857600;
   localparam logic [SCALE_W-1:0]   CELL_SCALE_RST = 16'd512;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROT_ROW_X,
      CSR_ROT_ROW_Y,
      CSR_ROT_ROW_Z,
      CSR_TRANSLATION,
      CSR_HEIGHT_WINDOW,
      CSR_MAX_RANGE_SQ,
      CSR_CELL_SCALE
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC,
      ST_LOOKUP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] cell_x;
      logic signed [OUT_W-1:0] cell_y;
      logic                    status;
   } rsp_word_type;

   typedef struct packed {
      logic [47:0]        rot_row_x;
      logic [47:0]        rot_row_y;
      logic [47:0]        rot_row_z;
      logic [62:0]        translation;
      logic [31:0]        height_window;
      logic [RANGE_W-1:0] max_range_sq;
      logic [SCALE_W-1:0] cell_scale;
   } cfg_type;

   typedef struct packed {
      logic                    done;
      logic                    keep;
      logic                    outside;
      logic signed [OUT_W-1:0] cell_x;
      logic signed [OUT_W-1:0] cell_y;
      logic [BIT_SEL_W-1:0]    bit_sel;
   } xf_res_type;

   typedef struct packed {
      logic rd_en;
      logic set_en;
   } bm_ctl_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } bm_sts_type;

endpackage

// ===== src/occupancy_grid_point_marker.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_point_marker
// Lidar point to occupancy grid marker: filters each point by range and
// world height, maps it to a grid cell and reports newly occupied cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel takes one sensor-frame point per word (req_valid/req_stall).
//   rsp_ channel gives at most one word per point: a newly marked cell with
//   status 0, or a cell outside the grid with status 1 (every hit).
//   csr_ port writes the pose, height window, range limit and cell scale;
//   write only while no point is in flight.
// Timing:
//   One point is in flight at a time. Each passes the four-stage transform
//   pipeline; a kept point inside the grid then reads its bitmap word on the
//   single memory port and writes it back if its bit was clear, and a point
//   with a word to emit waits for a free output register before the next.
// Reset:
//   After reset the bitmap memory is cleared one word per cycle, all
//   GRID_SIDE*GRID_SIDE/64 words (1024 at GRID_SIDE = 256), with req_stall
//   held high. Configuration returns to the identity pose and defaults.
// Stall:
//   A result waits in the output register while rsp_stall is high; the next
//   point is still accepted and its result holds until the register frees.
// ----------------------------------------------------------------------------
module occupancy_grid_point_marker #(
   parameter int GRID_SIDE = ogpm_pkg::GRID_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ogpm_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ogpm_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_wr_en,
   input  logic [ogpm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ogpm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int BIT_W  = $clog2(GRID_SIDE * GRID_SIDE);
   localparam int ADDR_W = BIT_W - ogpm_pkg::BIT_SEL_W;

   ogpm_pkg::cfg_type      cfg;
   ogpm_pkg::xf_res_type   xf_res;
   logic [ADDR_W-1:0]      xf_addr;
   ogpm_pkg::bm_ctl_type   bm_ctl;
   ogpm_pkg::bm_sts_type   bm_sts;

   ogpm_pkg::state_type    state_ff, state_in;
   logic                   launch;
   logic                   rsp_load;
   logic                   rsp_valid_ff, rsp_valid_in;
   ogpm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   ogpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ogpm_xform #(
      .GRID_SIDE (GRID_SIDE),
      .BIT_W     (BIT_W),
      .ADDR_W    (ADDR_W)
   ) u_xform (
      .clock    (clock),
      .reset    (reset),
      .launch   (launch),
      .req_word (req_word),
      .cfg      (cfg),
      .res      (xf_res),
      .addr     (xf_addr)
   );

   ogpm_bitmap #(
      .GRID_SIDE (GRID_SIDE),
      .BIT_W     (BIT_W),
      .ADDR_W    (ADDR_W)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .ctl     (bm_ctl),
      .addr    (xf_addr),
      .bit_sel (xf_res.bit_sel),
      .sts     (bm_sts)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ogpm_pkg::ST_CLEAR: begin
            if (!bm_sts.busy) begin
               state_in = ogpm_pkg::ST_IDLE;
            end
         end
         ogpm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ogpm_pkg::ST_CALC;
            end
         end
         ogpm_pkg::ST_CALC: begin
            if (xf_res.done) begin
               if (!xf_res.keep) begin
                  state_in = ogpm_pkg::ST_IDLE;
               end else if (xf_res.outside) begin
                  state_in = ogpm_pkg::ST_EMIT;
               end else begin
                  state_in = ogpm_pkg::ST_LOOKUP;
               end
            end
         end
         ogpm_pkg::ST_LOOKUP: begin
            state_in = bm_sts.hit ? ogpm_pkg::ST_IDLE : ogpm_pkg::ST_EMIT;
         end
         ogpm_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ogpm_pkg::ST_IDLE;
            end
         end
         default: state_in = ogpm_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_stall     = 1'b1;
      launch        = 1'b0;
      bm_ctl.rd_en  = 1'b0;
      bm_ctl.set_en = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         ogpm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            launch    = req_valid;
         end
         ogpm_pkg::ST_CALC: begin
            bm_ctl.rd_en = xf_res.done && xf_res.keep && !xf_res.outside;
         end
         ogpm_pkg::ST_LOOKUP: begin
            bm_ctl.set_en = !bm_sts.hit;
         end
         ogpm_pkg::ST_EMIT: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_word_in.cell_x = xf_res.cell_x;
         rsp_word_in.cell_y = xf_res.cell_y;
         rsp_word_in.status = xf_res.outside ? ogpm_pkg::STATUS_OUTSIDE
                                             : ogpm_pkg::STATUS_NEW;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ogpm_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_no_access_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      bm_sts.busy |-> !(bm_ctl.rd_en || bm_ctl.set_en || launch)
   ) else $error("bitmap accessed during clearing sweep");

   a_set_follows_read: assert property (
      @(posedge clock) disable iff (reset)
      bm_ctl.set_en |-> ($past(bm_ctl.rd_en) && !bm_sts.hit)
   ) else $error("bitmap write without preceding read of a clear bit");

   a_pipeline_latency: assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##4 (xf_res.done && state_ff == ogpm_pkg::ST_CALC)
   ) else $error("transform result missing four cycles after acceptance");

   a_load_into_free_slot: assert property (
      @(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall)
   ) else $error("output register overwritten while stalled");

   a_done_only_in_calc: assert property (
      @(posedge clock) disable iff (reset)
      xf_res.done |-> (state_ff == ogpm_pkg::ST_CALC)
   ) else $error("transform result outside calculation phase");

endmodule

// ===== src/ogpm_csr.sv =====
// ----------------------------------------------------------------------------
// ogpm_csr
// Configuration registers: pose, height window, range limit and cell scale.
// ----------------------------------------------------------------------------
module ogpm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ogpm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ogpm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output ogpm_pkg::cfg_type                   cfg
);

   ogpm_pkg::cfg_type cfg_ff;
   ogpm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ogpm_pkg::CSR_ROT_ROW_X:     cfg_in.rot_row_x     = csr_wdata[47:0];
            ogpm_pkg::CSR_ROT_ROW_Y:     cfg_in.rot_row_y     = csr_wdata[47:0];
            ogpm_pkg::CSR_ROT_ROW_Z:     cfg_in.rot_row_z     = csr_wdata[47:0];
            ogpm_pkg::CSR_TRANSLATION:   cfg_in.translation   = csr_wdata[62:0];
            ogpm_pkg::CSR_HEIGHT_WINDOW: cfg_in.height_window = csr_wdata[31:0];
            ogpm_pkg::CSR_MAX_RANGE_SQ:
               cfg_in.max_range_sq = csr_wdata[ogpm_pkg::RANGE_W-1:0];
            ogpm_pkg::CSR_CELL_SCALE:
               cfg_in.cell_scale = csr_wdata[ogpm_pkg::SCALE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_row_x     <= ogpm_pkg::ROT_ROW_X_RST;
         cfg_ff.rot_row_y     <= ogpm_pkg::ROT_ROW_Y_RST;
         cfg_ff.rot_row_z     <= ogpm_pkg::ROT_ROW_Z_RST;
         cfg_ff.translation   <= ogpm_pkg::TRANS_RST;
         cfg_ff.height_window <= ogpm_pkg::HEIGHT_WIN_RST;
         cfg_ff.max_range_sq  <= ogpm_pkg::MAX_RANGE_RST;
         cfg_ff.cell_scale    <= ogpm_pkg::CELL_SCALE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/ogpm_xform.sv =====
// ----------------------------------------------------------------------------
// ogpm_xform
// Four-stage point pipeline: products, sums, filters and scaling, then cell
// index, grid test and bitmap address.
// ----------------------------------------------------------------------------
module ogpm_xform #(
   parameter int GRID_SIDE = ogpm_pkg::GRID_SIDE_DEF,
   parameter int BIT_W     = $clog2(GRID_SIDE * GRID_SIDE),
   parameter int ADDR_W    = BIT_W - ogpm_pkg::BIT_SEL_W
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     launch,
   input  ogpm_pkg::req_word_type   req_word,
   input  ogpm_pkg::cfg_type        cfg,
   output ogpm_pkg::xf_res_type     res,
   output logic [ADDR_W-1:0]        addr
);

   localparam int IDX_W = $clog2(GRID_SIDE);
   localparam int CW    = ogpm_pkg::CELL_W;
   localparam logic signed [CW-1:0] CELL_LO = CW'(-(GRID_SIDE / 2));
   localparam logic signed [CW-1:0] CELL_HI = CW'(GRID_SIDE - GRID_SIDE / 2 - 1);

   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1
   logic signed [ogpm_pkg::COORD_W-1:0] pt [3];
   logic        [ogpm_pkg::SQ_W-1:0]    sq_in [3];
   logic        [ogpm_pkg::SQ_W-1:0]    sq_ff [3];
   logic signed [ogpm_pkg::PROD_W-1:0]  mx_in [3];
   logic signed [ogpm_pkg::PROD_W-1:0]  my_in [3];
   logic signed [ogpm_pkg::PROD_W-1:0]  mz_in [3];
   logic signed [ogpm_pkg::PROD_W-1:0]  mx_ff [3];
   logic signed [ogpm_pkg::PROD_W-1:0]  my_ff [3];
   logic signed [ogpm_pkg::PROD_W-1:0]  mz_ff [3];

   // stage 2
   logic signed [ogpm_pkg::TRANS_W+ogpm_pkg::Q14_SHIFT-1:0] tx, ty, tz;
   logic        [ogpm_pkg::SQ_W-1:0]   r2_in, r2_ff;
   logic signed [ogpm_pkg::ACC_W-1:0]  wx_in, wy_in, wz_in;
   logic signed [ogpm_pkg::ACC_W-1:0]  wx_ff, wy_ff, wz_ff;

   // stage 3
   logic signed [ogpm_pkg::HW_W+ogpm_pkg::Q14_SHIFT-1:0] hmin, hmax;
   logic signed [ogpm_pkg::SCALE_W:0]    scale_s;
   logic                                 keep3_in, keep3_ff;
   logic signed [ogpm_pkg::SCALED_W-1:0] px_in, py_in, px_ff, py_ff;

   // stage 4
   logic signed [CW-1:0]      cx, cy, ux, uy;
   logic [IDX_W-1:0]          ix, iy;
   logic [BIT_W-1:0]          bit_idx;
   logic                      outside_in, outside_ff, keep4_ff;
   logic signed [ogpm_pkg::OUT_W-1:0] cell_x_in, cell_y_in, cell_x_ff, cell_y_ff;
   logic [ogpm_pkg::BIT_SEL_W-1:0]    bit_sel_ff;
   logic [ADDR_W-1:0]         addr_ff;

   function automatic logic signed [ogpm_pkg::OUT_W-1:0] sat_cell(
      input logic signed [CW-1:0] v
   );
      logic signed [ogpm_pkg::OUT_W-1:0] r;
      if (v > ogpm_pkg::SAT_HI) begin
         r = {1'b0, {(ogpm_pkg::OUT_W-1){1'b1}}};
      end else if (v < ogpm_pkg::SAT_LO) begin
         r = {1'b1, {(ogpm_pkg::OUT_W-1){1'b0}}};
      end else begin
         r = v[ogpm_pkg::OUT_W-1:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= launch;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      pt[0] = req_word.point_x;
      pt[1] = req_word.point_y;
      pt[2] = req_word.point_z;
      for (int c = 0; c < 3; c++) begin
         sq_in[c] = pt[c] * pt[c];
         mx_in[c] = $signed(cfg.rot_row_x[ogpm_pkg::ROT_W*c +: ogpm_pkg::ROT_W]) * pt[c];
         my_in[c] = $signed(cfg.rot_row_y[ogpm_pkg::ROT_W*c +: ogpm_pkg::ROT_W]) * pt[c];
         mz_in[c] = $signed(cfg.rot_row_z[ogpm_pkg::ROT_W*c +: ogpm_pkg::ROT_W]) * pt[c];
      end
   end

   always_ff @(posedge clock) begin
      if (launch) begin
         for (int c = 0; c < 3; c++) begin
            sq_ff[c] <= sq_in[c];
            mx_ff[c] <= mx_in[c];
            my_ff[c] <= my_in[c];
            mz_ff[c] <= mz_in[c];
         end
      end
   end

   always_comb begin
      tx = $signed({cfg.translation[ogpm_pkg::TRANS_W-1:0],
                    {ogpm_pkg::Q14_SHIFT{1'b0}}});
      ty = $signed({cfg.translation[2*ogpm_pkg::TRANS_W-1:ogpm_pkg::TRANS_W],
                    {ogpm_pkg::Q14_SHIFT{1'b0}}});
      tz = $signed({cfg.translation[3*ogpm_pkg::TRANS_W-1:2*ogpm_pkg::TRANS_W],
                    {ogpm_pkg::Q14_SHIFT{1'b0}}});
      r2_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
      wx_in = ogpm_pkg::ACC_W'(mx_ff[0]) + ogpm_pkg::ACC_W'(mx_ff[1])
            + ogpm_pkg::ACC_W'(mx_ff[2]) + ogpm_pkg::ACC_W'(tx);
      wy_in = ogpm_pkg::ACC_W'(my_ff[0]) + ogpm_pkg::ACC_W'(my_ff[1])
            + ogpm_pkg::ACC_W'(my_ff[2]) + ogpm_pkg::ACC_W'(ty);
      wz_in = ogpm_pkg::ACC_W'(mz_ff[0]) + ogpm_pkg::ACC_W'(mz_ff[1])
            + ogpm_pkg::ACC_W'(mz_ff[2]) + ogpm_pkg::ACC_W'(tz);
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         r2_ff <= r2_in;
         wx_ff <= wx_in;
         wy_ff <= wy_in;
         wz_ff <= wz_in;
      end
   end

   always_comb begin
      hmin = $signed({cfg.height_window[ogpm_pkg::HW_W-1:0],
                      {ogpm_pkg::Q14_SHIFT{1'b0}}});
      hmax = $signed({cfg.height_window[2*ogpm_pkg::HW_W-1:ogpm_pkg::HW_W],
                      {ogpm_pkg::Q14_SHIFT{1'b0}}});
      scale_s  = $signed({1'b0, cfg.cell_scale});
      keep3_in = (r2_ff > ogpm_pkg::MIN_RANGE_SQ)
              && (r2_ff < ogpm_pkg::SQ_W'(cfg.max_range_sq))
              && (wz_ff > ogpm_pkg::ACC_W'(hmin))
              && (wz_ff < ogpm_pkg::ACC_W'(hmax));
      px_in = wx_ff * scale_s;
      py_in = wy_ff * scale_s;
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         keep3_ff <= keep3_in;
         px_ff    <= px_in;
         py_ff    <= py_in;
      end
   end

   always_comb begin
      cx = $signed(px_ff[ogpm_pkg::SCALED_W-1:ogpm_pkg::SCALE_SHIFT]);
      cy = $signed(py_ff[ogpm_pkg::SCALED_W-1:ogpm_pkg::SCALE_SHIFT]);
      outside_in = (cx < CELL_LO) || (cx > CELL_HI) || (cy < CELL_LO) || (cy > CELL_HI);
      ux = cx - CELL_LO;
      uy = cy - CELL_LO;
      ix = ux[IDX_W-1:0];
      iy = uy[IDX_W-1:0];
      bit_idx = BIT_W'(iy) * BIT_W'(GRID_SIDE) + BIT_W'(ix);
      cell_x_in = sat_cell(cx);
      cell_y_in = sat_cell(cy);
   end

   always_ff @(posedge clock) begin
      if (v3_ff) begin
         keep4_ff   <= keep3_ff;
         outside_ff <= outside_in;
         cell_x_ff  <= cell_x_in;
         cell_y_ff  <= cell_y_in;
         bit_sel_ff <= bit_idx[ogpm_pkg::BIT_SEL_W-1:0];
         addr_ff    <= bit_idx[BIT_W-1:ogpm_pkg::BIT_SEL_W];
      end
   end

   assign res.done    = v4_ff;
   assign res.keep    = keep4_ff;
   assign res.outside = outside_ff;
   assign res.cell_x  = cell_x_ff;
   assign res.cell_y  = cell_y_ff;
   assign res.bit_sel = bit_sel_ff;
   assign addr        = addr_ff;

endmodule

// ===== src/ogpm_bitmap.sv =====
// ----------------------------------------------------------------------------
// ogpm_bitmap
// Occupancy bitmap in one synchronous memory of 64-bit words: clearing sweep
// after reset, registered read, and set-bit write back of the read word.
// ----------------------------------------------------------------------------
module ogpm_bitmap #(
   parameter int GRID_SIDE = ogpm_pkg::GRID_SIDE_DEF,
   parameter int BIT_W     = $clog2(GRID_SIDE * GRID_SIDE),
   parameter int ADDR_W    = BIT_W - ogpm_pkg::BIT_SEL_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ogpm_pkg::bm_ctl_type            ctl,
   input  logic [ADDR_W-1:0]               addr,
   input  logic [ogpm_pkg::BIT_SEL_W-1:0]  bit_sel,
   output ogpm_pkg::bm_sts_type            sts
);

   localparam int WORDS = (GRID_SIDE * GRID_SIDE + ogpm_pkg::WORD_W - 1) / ogpm_pkg::WORD_W;
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORDS - 1);

   logic [ogpm_pkg::WORD_W-1:0] mem_ff [WORDS];
   logic [ogpm_pkg::WORD_W-1:0] rdata_ff;
   logic                        clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]           clr_cnt_ff, clr_cnt_in;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ogpm_pkg::WORD_W-1:0] wr_data;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_WORD) begin
            clr_busy_in = 1'b0;
         end
      end
      wr_en   = clr_busy_ff || ctl.set_en;
      wr_addr = clr_busy_ff ? clr_cnt_ff : addr;
      wr_data = clr_busy_ff ? '0
              : (rdata_ff | (ogpm_pkg::WORD_W'(1) << bit_sel));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign sts.busy = clr_busy_ff;
   assign sts.hit  = rdata_ff[bit_sel];

endmodule
